@@ design/srrc_pkg.sv @@
package srrc_pkg;

  // Decoder phases
  localparam logic [2:0] PH_TLO  = 3'd0;
  localparam logic [2:0] PH_THI  = 3'd1;
  localparam logic [2:0] PH_OLO  = 3'd2;
  localparam logic [2:0] PH_OHI  = 3'd3;
  localparam logic [2:0] PH_C0   = 3'd4;
  localparam logic [2:0] PH_C1   = 3'd5;
  localparam logic [2:0] PH_C2   = 3'd6;
  localparam logic [2:0] PH_DROP = 3'd7;

  // Result status codes
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_GOOD  = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  localparam logic [7:0]  ALPHA_BYTE   = 8'hFF;
  localparam logic [16:0] COUNT_MAX    = 17'h1FFFF;
  localparam logic [16:0] LIMIT_RESET  = 17'd1024;
  localparam int          QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic        last_of_sprite;
    logic [16:0] total_length;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [16:0] pixels_left;
    logic [7:0]  held_low_byte;
    logic [15:0] run_left;
    logic [16:0] out_count;
  } dec_state_t;

endpackage

@@ design/srrc_step.sv @@
module srrc_step (
  input  srrc_pkg::dec_state_t st,
  input  logic [16:0]          pixel_limit,
  input  srrc_pkg::in_word_t   in_word,
  output srrc_pkg::dec_state_t st_nxt,
  output logic [1:0]           res_n,
  output srrc_pkg::out_word_t  res0,
  output srrc_pkg::out_word_t  res1
);
  import srrc_pkg::*;

  logic [7:0]  b;
  logic        last;
  logic [15:0] run_n;
  logic        over;
  logic [16:0] cnt1;
  logic [16:0] cnt2;
  logic [15:0] run_dec;
  dec_state_t  restart;

  assign b       = in_word.in_byte;
  assign last    = in_word.in_last;
  assign run_n   = {b, st.held_low_byte};
  assign over    = {1'b0, run_n} > st.pixels_left;
  assign cnt1    = (st.out_count == COUNT_MAX) ? st.out_count : st.out_count + 17'd1;
  assign cnt2    = (cnt1 == COUNT_MAX) ? cnt1 : cnt1 + 17'd1;
  assign run_dec = st.run_left - 16'd1;

  // Sprite state for the next sprite
  always_comb begin
    restart               = '0;
    restart.phase         = PH_TLO;
    restart.pixels_left   = pixel_limit;
  end

  // Decode one byte into up to two result words
  always_comb begin
    st_nxt = st;
    res_n  = 2'd0;
    res0   = '0;
    res1   = '0;
    case (st.phase)
      PH_TLO, PH_OLO, PH_C0, PH_C1: begin
        res_n = 2'd1;
        if (last) begin
          res0.status         = ST_TRUNC;
          res0.last_of_sprite = 1'b1;
          st_nxt              = restart;
        end else begin
          if (st.phase == PH_TLO || st.phase == PH_OLO) begin
            st_nxt.held_low_byte = b;
          end
          st_nxt.phase     = st.phase + 3'd1;
          st_nxt.out_count = cnt1;
          res0.out_byte    = b;
        end
      end
      PH_THI, PH_OHI: begin
        res_n = 2'd1;
        if (over) begin
          res0.status         = ST_OVER;
          res0.last_of_sprite = 1'b1;
          if (last) begin
            st_nxt = restart;
          end else begin
            st_nxt.phase = PH_DROP;
          end
        end else if (st.phase == PH_OHI && run_n == 16'd0) begin
          if (last) begin
            res0.out_byte       = b;
            res0.status         = ST_GOOD;
            res0.last_of_sprite = 1'b1;
            res0.total_length   = cnt1;
            st_nxt              = restart;
          end else begin
            st_nxt.pixels_left = st.pixels_left - {1'b0, run_n};
            st_nxt.run_left    = run_n;
            st_nxt.phase       = PH_TLO;
            st_nxt.out_count   = cnt1;
            res0.out_byte      = b;
          end
        end else if (last) begin
          res0.status         = ST_TRUNC;
          res0.last_of_sprite = 1'b1;
          st_nxt              = restart;
        end else begin
          st_nxt.pixels_left = st.pixels_left - {1'b0, run_n};
          st_nxt.out_count   = cnt1;
          res0.out_byte      = b;
          if (st.phase == PH_THI) begin
            st_nxt.phase = PH_OLO;
          end else begin
            st_nxt.run_left = run_n;
            st_nxt.phase    = PH_C0;
          end
        end
      end
      PH_C2: begin
        if (last && run_dec != 16'd0) begin
          res_n               = 2'd1;
          res0.status         = ST_TRUNC;
          res0.last_of_sprite = 1'b1;
          st_nxt              = restart;
        end else begin
          res_n         = 2'd2;
          res0.out_byte = b;
          res1.out_byte = ALPHA_BYTE;
          if (last) begin
            res1.status         = ST_GOOD;
            res1.last_of_sprite = 1'b1;
            res1.total_length   = cnt2;
            st_nxt              = restart;
          end else begin
            st_nxt.run_left  = run_dec;
            st_nxt.out_count = cnt2;
            st_nxt.phase     = (run_dec == 16'd0) ? PH_TLO : PH_C0;
          end
        end
      end
      default: begin
        // Drop bytes until the end of the sprite
        if (last) begin
          st_nxt = restart;
        end
      end
    endcase
  end

endmodule

@@ design/srrc_queue.sv @@
module srrc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  srrc_pkg::out_word_t push0,
  input  srrc_pkg::out_word_t push1,
  input  logic                pop,
  output logic                not_empty,
  output logic                room_for_two,
  output srrc_pkg::out_word_t head
);
  import srrc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  out_word_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr_r + PTR_W'(1);
  assign not_empty    = count_r != '0;
  assign room_for_two = count_r <= CNT_W'(QUEUE_DEPTH - 2);
  assign head         = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_plus1] <= push1;
    end
  end

endmodule

@@ design/sprite_rle_rgb_to_rgba_converter_core.sv @@
// Run-length sprite converter: RGB opaque runs in, RGBA opaque runs out.
// Input channel (in_valid/in_stall/in_data) carries one payload byte a word,
// with in_last on the final byte of a sprite. Output channel
// (out_valid/out_stall/out_data) carries converted bytes, the end-of-sprite
// word with the total length, or a single error word.
// cfg_valid/cfg_data loads the pixel budget; cfg_ready is always high and a
// write also restarts the budget of the sprite in progress. Write it only
// while the block is idle.
// Each accepted byte is decoded in the cycle it is taken and its zero, one or
// two result words are registered into a four-word output queue whose head
// drives out_data. A byte is taken every cycle while the queue holds at most
// two words, so count and colour bytes run at one per cycle and a colour
// triple yields four words; the single output port sets the sustained rate
// of one output word per cycle while out_stall is low.
// in_stall rises when the queue holds more than two words, so a stall on the
// output backs up to the input without losing a word.
// Reset empties the queue, sets the budget to 1024 and waits for the
// transparent count of a new record.
module sprite_rle_rgb_to_rgba_converter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srrc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srrc_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [16:0]         cfg_data
);
  import srrc_pkg::*;

  dec_state_t  st_r, st_nxt, step_nxt;
  logic [16:0] pixel_limit_r;
  logic        in_take;
  logic        room;
  logic [1:0]  res_n;
  logic [1:0]  push_n;
  out_word_t   res0, res1;

  assign cfg_ready = 1'b1;
  assign in_stall  = !room;
  assign in_take   = in_valid && room;
  assign push_n    = in_take ? res_n : 2'd0;

  srrc_step u_step (
    .st          (st_r),
    .pixel_limit (pixel_limit_r),
    .in_word     (in_data),
    .st_nxt      (step_nxt),
    .res_n       (res_n),
    .res0        (res0),
    .res1        (res1)
  );

  srrc_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_n       (push_n),
    .push0        (res0),
    .push1        (res1),
    .pop          (out_valid && !out_stall),
    .not_empty    (out_valid),
    .room_for_two (room),
    .head         (out_data)
  );

  // Advance decoder state; a budget write reloads the pixels left
  always_comb begin
    st_nxt = in_take ? step_nxt : st_r;
    if (cfg_valid) begin
      st_nxt.pixels_left = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r                <= '{PH_TLO, LIMIT_RESET, 8'd0, 16'd0, 17'd0};
      pixel_limit_r       <= LIMIT_RESET;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) begin
        pixel_limit_r <= cfg_data;
      end
    end
  end

endmodule
